@@ src/sensor_average_report_formatter_assert.svh @@
// assertion macros for the sensor average report formatter checker
// no dependencies; taken in by the checker file
`ifndef SENSOR_AVERAGE_REPORT_FORMATTER_ASSERT_SVH
`define SENSOR_AVERAGE_REPORT_FORMATTER_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define SARF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sarf check failed");

// next-cycle implication, quiet while reset is high
`define SARF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sarf check failed");

// condition that must hold in the cycle after reset
`define SARF_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("sarf reset check failed");

`endif

@@ src/sarf_pkg.sv @@
// shared types, constants and codes for the sensor average report formatter
// no dependencies; used by every module of the block
package sarf_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int QUEUE_DEPTH = 8;
   localparam int MUL_W       = 14;
   localparam int MAG_W       = 10;

   // register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_ALPHA       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VCC_ALPHA        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_READY_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VCC_READY_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_FORMULA   = 3'd4;

   localparam logic [7:0] TEMP_ALPHA_RESET  = 8'd64;
   localparam logic [7:0] VCC_ALPHA_RESET   = 8'd64;
   localparam logic [7:0] READY_COUNT_RESET = 8'd20;
   localparam logic [7:0] COUNT_MAX         = 8'd255;

   localparam logic FORMULA_OLD = 1'b0;
   localparam logic FORMULA_NEW = 1'b1;

   // item kinds
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_BYTE   = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic KIND_TEMP = 1'b0;
   localparam logic KIND_VOLT = 1'b1;

   // sensor scaling
   localparam int TEMP_C_OLD_MUL   = 11;
   localparam int TEMP_C_OLD_SHIFT = 6;
   localparam int TEMP_C_OLD_OFS   = 278;
   localparam int TEMP_F_OLD_MUL   = 315;
   localparam int TEMP_F_OLD_SHIFT = 10;
   localparam int TEMP_F_OLD_OFS   = 468;
   localparam int TEMP_C_NEW_MUL   = 8889;
   localparam int TEMP_C_NEW_SHIFT = 10;
   localparam int TEMP_C_NEW_OFS   = 9671;
   localparam int TEMP_C_NEW_DIV   = 5;
   localparam int TEMP_F_NEW_MUL   = 125;
   localparam int TEMP_F_NEW_SHIFT = 8;
   localparam int TEMP_F_NEW_OFS   = 512;
   localparam int TEMP_MAX         = 999;
   localparam int TEMP_MIN         = -99;

   // divide by 82 as multiply by reciprocal, exact below the saturation point
   localparam int VOLT_DIVISOR     = 82;
   localparam int VOLT_MAX         = 99;
   localparam int VOLT_SAT_LIMIT   = VOLT_DIVISOR * (VOLT_MAX + 1);
   localparam int VOLT_RECIP_SHIFT = 20;
   localparam int VOLT_RECIP_MUL   = ((1 << VOLT_RECIP_SHIFT) + VOLT_DIVISOR - 1) / VOLT_DIVISOR;

   localparam int DIV100_MUL   = 41;
   localparam int DIV100_SHIFT = 12;
   localparam int DIV10_MUL    = 103;
   localparam int DIV10_SHIFT  = 10;

   // ascii
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_DEG   = 8'h6f;
   localparam logic [7:0] CHAR_C_UP  = 8'h43;
   localparam logic [7:0] CHAR_C_LO  = 8'h63;
   localparam logic [7:0] CHAR_F_UP  = 8'h46;
   localparam logic [7:0] CHAR_F_LO  = 8'h66;
   localparam logic [7:0] CHAR_V_UP  = 8'h56;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   typedef struct packed {
      logic [1:0]             mode;
      logic [SAMPLE_BITS-1:0] temp_sample;
      logic [SAMPLE_BITS-1:0] vcc_sample;
      logic [7:0]             rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       report_kind;
      logic       last_char;
   } rsp_type;

   // one formatted report waiting for the serialiser
   typedef struct packed {
      logic       kind;
      logic       fahr;
      logic       neg;
      logic [1:0] nd;
      logic [3:0] d_h;
      logic [3:0] d_t;
      logic [3:0] d_o;
   } report_entry_type;

   typedef struct packed {
      logic             valid;
      report_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic             valid;
      report_entry_type entry;
   } queue_head_type;

endpackage

@@ src/sarf_front.sv @@
// front end: config registers, averages, ready flags and report value pipeline
// depends on sarf_pkg; feeds sarf_queue
module sarf_front #(
   parameter int QueueDepth = sarf_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sarf_pkg::req_type                  req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sarf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                         csr_wdata,
   input  logic                               pop,
   output sarf_pkg::queue_push_type           push
);
   import sarf_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int EMA_W  = SB + 10;
   localparam int PROD_W = SB + MUL_W;
   localparam int VAL_W  = PROD_W - 5;
   localparam int OCC_W  = $clog2(QueueDepth + 1);

   // configuration
   logic [7:0] temp_alpha_ff, temp_alpha_in;
   logic [7:0] vcc_alpha_ff, vcc_alpha_in;
   logic [7:0] temp_rc_ff, temp_rc_in;
   logic [7:0] vcc_rc_ff, vcc_rc_in;
   logic       formula_ff, formula_in;

   // state
   logic [SB-1:0] temp_mean_ff, temp_mean_in;
   logic [SB-1:0] vcc_mean_ff, vcc_mean_in;
   logic [7:0]    count_ff, count_in;
   logic          temp_ready_ff, temp_ready_in;
   logic          vcc_ready_ff, vcc_ready_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic accept, is_c, is_f, report_temp, report_volt, report_any, do_sample;
   logic [7:0] count_next;

   logic signed [SB:0]      t_diff, v_diff;
   logic signed [EMA_W-1:0] t_prod, v_prod, t_step, v_step;

   // pipeline
   logic          s1_valid_ff, s1_kind_ff, s1_fahr_ff;
   logic [SB-1:0] s1_mean_ff;
   logic              s2_valid_ff, s2_kind_ff, s2_fahr_ff, s2_sat_ff;
   logic [PROD_W-1:0] s2_prod_ff;
   logic              s3_valid_ff, s3_kind_ff, s3_fahr_ff, s3_neg_ff;
   logic [MAG_W-1:0]  s3_mag_ff;
   logic              s4_valid_ff, s4_kind_ff, s4_fahr_ff, s4_neg_ff;
   logic [1:0]        s4_nd_ff;
   logic [3:0]        s4_hund_ff;
   logic [6:0]        s4_rem_ff;

   logic [MUL_W-1:0]  k_sel;
   logic [PROD_W-1:0] prod;
   logic              sat;

   logic signed [VAL_W-1:0] sh_c_old, sh_10, sh_f_new, c_new_diff, t_raw, t_sat, t_abs;
   logic [PROD_W-1:0]       volt_q;
   logic [MAG_W-1:0]        mag;

   logic [15:0]      hund_prod;
   logic [3:0]       hund;
   logic [MAG_W-1:0] rem_full;
   logic [1:0]       nd;

   logic [13:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  ones_full;

   assign csr_ready = 1'b1;
   assign req_ready = occ_ff < OCC_W'(QueueDepth);
   assign accept    = req_valid && req_ready;

   // item decode
   always_comb begin
      is_c        = (req_data.rx_byte == CHAR_C_LO) || (req_data.rx_byte == CHAR_C_UP);
      is_f        = (req_data.rx_byte == CHAR_F_LO) || (req_data.rx_byte == CHAR_F_UP);
      report_temp = 1'b0;
      report_volt = 1'b0;
      do_sample   = 1'b0;
      unique case (req_data.mode)
         MODE_SAMPLE: do_sample   = 1'b1;
         MODE_BYTE:   report_temp = (is_c || is_f) && temp_ready_ff;
         MODE_TICK:   report_volt = vcc_ready_ff;
         MODE_NONE:   do_sample   = 1'b0;
         default:     do_sample   = 1'b0;
      endcase
      report_any = report_temp || report_volt;
   end

   // averages: mean + floor(alpha * (x - mean) / 256)
   always_comb begin
      t_diff = signed'({1'b0, req_data.temp_sample}) - signed'({1'b0, temp_mean_ff});
      v_diff = signed'({1'b0, req_data.vcc_sample}) - signed'({1'b0, vcc_mean_ff});
      t_prod = EMA_W'(t_diff) * EMA_W'(signed'({1'b0, temp_alpha_ff}));
      v_prod = EMA_W'(v_diff) * EMA_W'(signed'({1'b0, vcc_alpha_ff}));
      t_step = t_prod >>> 8;
      v_step = v_prod >>> 8;
   end

   always_comb begin
      temp_mean_in  = temp_mean_ff;
      vcc_mean_in   = vcc_mean_ff;
      count_in      = count_ff;
      temp_ready_in = temp_ready_ff;
      vcc_ready_in  = vcc_ready_ff;
      count_next    = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;
      if (accept && do_sample) begin
         temp_mean_in = temp_mean_ff + t_step[SB-1:0];
         vcc_mean_in  = vcc_mean_ff + v_step[SB-1:0];
         // counter and flags freeze once both are set
         if (!temp_ready_ff || !vcc_ready_ff) begin
            count_in      = count_next;
            temp_ready_in = count_next >= temp_rc_ff;
            vcc_ready_in  = count_next >= vcc_rc_ff;
         end
      end
   end

   always_comb begin
      temp_alpha_in = temp_alpha_ff;
      vcc_alpha_in  = vcc_alpha_ff;
      temp_rc_in    = temp_rc_ff;
      vcc_rc_in     = vcc_rc_ff;
      formula_in    = formula_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_ALPHA:       temp_alpha_in = csr_wdata;
            CSR_VCC_ALPHA:        vcc_alpha_in  = csr_wdata;
            CSR_TEMP_READY_COUNT: temp_rc_in    = csr_wdata;
            CSR_VCC_READY_COUNT:  vcc_rc_in     = csr_wdata;
            CSR_SENSOR_FORMULA:   formula_in    = csr_wdata[0];
            default:              formula_in    = formula_ff;
         endcase
      end
   end

   // reports in the pipeline or queue; freed when the serialiser drops an entry
   always_comb begin
      occ_in = occ_ff;
      if (accept && report_any && !pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (!(accept && report_any) && pop) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   // stage 2: scale by the sensor or reciprocal constant
   always_comb begin
      if (s1_kind_ff == KIND_VOLT) begin
         k_sel = MUL_W'(VOLT_RECIP_MUL);
      end else begin
         case ({formula_ff, s1_fahr_ff})
            {FORMULA_OLD, 1'b0}: k_sel = MUL_W'(TEMP_C_OLD_MUL);
            {FORMULA_OLD, 1'b1}: k_sel = MUL_W'(TEMP_F_OLD_MUL);
            {FORMULA_NEW, 1'b0}: k_sel = MUL_W'(TEMP_C_NEW_MUL);
            default:             k_sel = MUL_W'(TEMP_F_NEW_MUL);
         endcase
      end
      prod = {{MUL_W{1'b0}}, s1_mean_ff} * {{SB{1'b0}}, k_sel};
      sat  = {{(32 - SB){1'b0}}, s1_mean_ff} >= 32'(VOLT_SAT_LIMIT);
   end

   // stage 3: offset, saturate, split sign and magnitude
   always_comb begin
      sh_c_old   = signed'(VAL_W'(s2_prod_ff >> TEMP_C_OLD_SHIFT));
      sh_10      = signed'(VAL_W'(s2_prod_ff >> TEMP_F_OLD_SHIFT));
      sh_f_new   = signed'(VAL_W'(s2_prod_ff >> TEMP_F_NEW_SHIFT));
      c_new_diff = signed'(VAL_W'(s2_prod_ff >> TEMP_C_NEW_SHIFT)) - VAL_W'(TEMP_C_NEW_OFS);
      case ({formula_ff, s2_fahr_ff})
         {FORMULA_OLD, 1'b0}: t_raw = sh_c_old - VAL_W'(TEMP_C_OLD_OFS);
         {FORMULA_OLD, 1'b1}: t_raw = sh_10 - VAL_W'(TEMP_F_OLD_OFS);
         {FORMULA_NEW, 1'b0}: t_raw = c_new_diff >>> TEMP_C_NEW_DIV;
         default:             t_raw = sh_f_new - VAL_W'(TEMP_F_NEW_OFS);
      endcase
      if (t_raw > VAL_W'(TEMP_MAX)) begin
         t_sat = VAL_W'(TEMP_MAX);
      end else if (t_raw < VAL_W'(TEMP_MIN)) begin
         t_sat = VAL_W'(TEMP_MIN);
      end else begin
         t_sat = t_raw;
      end
      t_abs  = t_sat[VAL_W-1] ? -t_sat : t_sat;
      volt_q = s2_prod_ff >> VOLT_RECIP_SHIFT;
      if (s2_kind_ff == KIND_VOLT) begin
         mag = s2_sat_ff ? MAG_W'(VOLT_MAX) : volt_q[MAG_W-1:0];
      end else begin
         mag = t_abs[MAG_W-1:0];
      end
   end

   // stage 4: hundreds digit and digit count
   always_comb begin
      hund_prod = 16'(s3_mag_ff) * 16'(DIV100_MUL);
      hund      = hund_prod[DIV100_SHIFT +: 4];
      rem_full  = s3_mag_ff - MAG_W'(hund) * MAG_W'(100);
      if (s3_kind_ff == KIND_VOLT || (s3_mag_ff > MAG_W'(9) && s3_mag_ff <= MAG_W'(99))) begin
         nd = 2'd2;
      end else if (s3_mag_ff > MAG_W'(99)) begin
         nd = 2'd3;
      end else begin
         nd = 2'd1;
      end
   end

   // tens and ones on the way into the queue
   always_comb begin
      tens_prod       = 14'(s4_rem_ff) * 14'(DIV10_MUL);
      tens            = tens_prod[DIV10_SHIFT +: 4];
      ones_full       = s4_rem_ff - 7'(tens) * 7'(10);
      push.valid      = s4_valid_ff;
      push.entry.kind = s4_kind_ff;
      push.entry.fahr = s4_fahr_ff;
      push.entry.neg  = s4_neg_ff;
      push.entry.nd   = s4_nd_ff;
      push.entry.d_h  = s4_hund_ff;
      push.entry.d_t  = tens;
      push.entry.d_o  = ones_full[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_alpha_ff <= TEMP_ALPHA_RESET;
         vcc_alpha_ff  <= VCC_ALPHA_RESET;
         temp_rc_ff    <= READY_COUNT_RESET;
         vcc_rc_ff     <= READY_COUNT_RESET;
         formula_ff    <= FORMULA_OLD;
         temp_mean_ff  <= '0;
         vcc_mean_ff   <= '0;
         count_ff      <= '0;
         temp_ready_ff <= 1'b0;
         vcc_ready_ff  <= 1'b0;
         occ_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
      end else begin
         temp_alpha_ff <= temp_alpha_in;
         vcc_alpha_ff  <= vcc_alpha_in;
         temp_rc_ff    <= temp_rc_in;
         vcc_rc_ff     <= vcc_rc_in;
         formula_ff    <= formula_in;
         temp_mean_ff  <= temp_mean_in;
         vcc_mean_ff   <= vcc_mean_in;
         count_ff      <= count_in;
         temp_ready_ff <= temp_ready_in;
         vcc_ready_ff  <= vcc_ready_in;
         occ_ff        <= occ_in;
         s1_valid_ff   <= accept && report_any;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
      end
   end

   // payload stages, snapshot of the mean taken with the request
   always_ff @(posedge clock) begin
      s1_kind_ff <= report_volt ? KIND_VOLT : KIND_TEMP;
      s1_fahr_ff <= is_f;
      s1_mean_ff <= report_volt ? vcc_mean_ff : temp_mean_ff;
      s2_kind_ff <= s1_kind_ff;
      s2_fahr_ff <= s1_fahr_ff;
      s2_sat_ff  <= sat;
      s2_prod_ff <= prod;
      s3_kind_ff <= s2_kind_ff;
      s3_fahr_ff <= s2_fahr_ff;
      s3_neg_ff  <= (s2_kind_ff == KIND_TEMP) && t_sat[VAL_W-1];
      s3_mag_ff  <= mag;
      s4_kind_ff <= s3_kind_ff;
      s4_fahr_ff <= s3_fahr_ff;
      s4_neg_ff  <= s3_neg_ff;
      s4_nd_ff   <= nd;
      s4_hund_ff <= hund;
      s4_rem_ff  <= rem_full[6:0];
   end

endmodule

@@ src/sarf_queue.sv @@
// report queue between the value pipeline and the character serialiser
// depends on sarf_pkg; written by sarf_front, read by sarf_back
module sarf_queue #(
   parameter int QueueDepth = sarf_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sarf_pkg::queue_push_type push,
   input  logic                     pop,
   output sarf_pkg::queue_head_type head
);
   import sarf_pkg::*;

   localparam int PTR_W   = $clog2(QueueDepth);
   localparam int COUNT_W = $clog2(QueueDepth + 1);

   report_entry_type entries_ff [QueueDepth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
      head.valid = count_ff != '0;
      head.entry = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ src/sarf_back.sv @@
// back end: turns queued reports into ascii words, one per cycle unless stalled
// depends on sarf_pkg; reads sarf_queue and drives the result channel
module sarf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sarf_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sarf_pkg::rsp_type        rsp_data
);
   import sarf_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load, is_last;
   logic [7:0] ch;

   function automatic logic [7:0] char_at(report_entry_type e, logic [2:0] pos);
      logic [2:0] nd3, idx, di, k;
      logic [3:0] dig;
      logic [7:0] c;
      nd3 = {1'b0, e.nd};
      idx = pos - {2'b00, e.neg};
      di  = idx + 3'd3 - nd3;
      k   = idx - nd3;
      case (di)
         3'd0:    dig = e.d_h;
         3'd1:    dig = e.d_t;
         default: dig = e.d_o;
      endcase
      if (e.kind == KIND_VOLT) begin
         case (pos)
            3'd0:    c = CHAR_ZERO + {4'b0000, e.d_t};
            3'd1:    c = CHAR_DOT;
            3'd2:    c = CHAR_ZERO + {4'b0000, e.d_o};
            3'd3:    c = CHAR_V_UP;
            3'd4:    c = CHAR_LF;
            default: c = CHAR_CR;
         endcase
      end else if (e.neg && pos == 3'd0) begin
         c = CHAR_MINUS;
      end else if (idx < nd3) begin
         c = CHAR_ZERO + {4'b0000, dig};
      end else begin
         case (k)
            3'd0:    c = CHAR_DEG;
            3'd1:    c = e.fahr ? CHAR_F_UP : CHAR_C_UP;
            3'd2:    c = CHAR_LF;
            default: c = CHAR_CR;
         endcase
      end
      return c;
   endfunction

   function automatic logic [2:0] last_pos(report_entry_type e);
      logic [2:0] lp;
      // voltage text is always six words; temperature is sign, digits and four more
      if (e.kind == KIND_VOLT) begin
         lp = 3'd5;
      end else begin
         lp = {2'b00, e.neg} + {1'b0, e.nd} + 3'd3;
      end
      return lp;
   endfunction

   assign load    = head.valid && (!rsp_valid_ff || rsp_ready);
   assign ch      = char_at(head.entry, pos_ff);
   assign is_last = pos_ff == last_pos(head.entry);

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.text_char   = ch;
         rsp_data_in.report_kind = head.entry.kind;
         rsp_data_in.last_char   = is_last;
         if (is_last) begin
            pos_in = '0;
            pop    = 1'b1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/sensor_average_report_formatter.sv @@
// any word is taken while fewer than QueueDepth reports are pending, and every word
// waits while that many are. a taken report passes stages s1 to s4 and the queue
// before its first text word is registered, then one word per cycle while rsp_ready
// holds: 5 to 7 words per report, so the character serialiser sets the sustained rate.
// synchronous reset: registers to defaults, averages, counter and flags to zero,
// queue empty; words are taken in the first cycle after reset falls
module sensor_average_report_formatter #(
   parameter int QueueDepth = sarf_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sarf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sarf_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sarf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import sarf_pkg::*;

   queue_push_type push;
   queue_head_type head;
   logic           pop;

   sarf_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop       (pop),
      .push      (push)
   );

   sarf_queue #(
      .QueueDepth(QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   sarf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/sarf_checker.sv @@
// port-level checks on the report text channel, bound to the top level
// depends on sarf_pkg and sensor_average_report_formatter_assert.svh
`include "sensor_average_report_formatter_assert.svh"

module sarf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sarf_pkg::rsp_type rsp_data
);
   import sarf_pkg::*;

   logic stalled, lf_taken, cr_offered, last_matches;

   assign stalled      = rsp_valid && !rsp_ready;
   assign lf_taken     = rsp_valid && rsp_ready && (rsp_data.text_char == CHAR_LF);
   assign cr_offered   = rsp_valid && (rsp_data.text_char == CHAR_CR);
   assign last_matches = rsp_data.last_char == (rsp_data.text_char == CHAR_CR);

   // a stalled word holds
   `SARF_ASSERT_NEXT(a_stall_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))
   // the closing flag marks exactly the carriage return
   `SARF_ASSERT_SAME(a_last_is_cr, clock, reset, rsp_valid, last_matches)
   // line feed is followed straight away by the carriage return
   `SARF_ASSERT_NEXT(a_lf_then_cr, clock, reset, lf_taken, cr_offered)
   // nothing offered right after reset
   `SARF_ASSERT_RESET(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind sensor_average_report_formatter sarf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ dv/sarf_report_checker.sv @@
`timescale 1ns / 1ps
// watches the request, register and report channels of the sensor average report
// formatter, predicts every report word and compares; depends on sarf_pkg
module sarf_report_checker
   import sarf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   fault_count,
   output int                   words_owed
);

   // sensor scalings: gain, shift, offset
   localparam int OLD_C_GAIN = 11;
   localparam int OLD_C_SHR  = 6;
   localparam int OLD_C_OFS  = 278;
   localparam int OLD_F_GAIN = 315;
   localparam int OLD_F_SHR  = 10;
   localparam int OLD_F_OFS  = 468;
   localparam int NEW_C_GAIN = 8889;
   localparam int NEW_C_SHR  = 10;
   localparam int NEW_C_OFS  = 9671;
   localparam int NEW_C_DIV  = 5;
   localparam int NEW_F_GAIN = 125;
   localparam int NEW_F_SHR  = 8;
   localparam int NEW_F_OFS  = 512;
   localparam int HOT_LIMIT  = 999;
   localparam int COLD_LIMIT = -99;
   localparam int VOLT_STEP  = 82;
   localparam int VOLT_CAP   = 99;

   logic [7:0]             temp_alpha;
   logic [7:0]             vcc_alpha;
   logic [7:0]             temp_ready_count;
   logic [7:0]             vcc_ready_count;
   logic                   sensor_formula;

   logic [SAMPLE_BITS-1:0] temp_mean;
   logic [SAMPLE_BITS-1:0] vcc_mean;
   logic [7:0]             sample_count;
   logic                   temp_ready;
   logic                   vcc_ready;

   rsp_type                report_words_q[$];
   int                     fault_total = 0;

   assign fault_count = fault_total;

   function automatic logic [SAMPLE_BITS-1:0] smooth(logic [7:0] alpha,
                                                     logic [SAMPLE_BITS-1:0] x,
                                                     logic [SAMPLE_BITS-1:0] m);
      int acc;
      acc = (int'(alpha) * int'(x) + (256 - int'(alpha)) * int'(m)) >> 8;
      return acc[SAMPLE_BITS-1:0];
   endfunction

   function automatic int temp_reading(logic fahr);
      int m;
      int t;
      m = int'(temp_mean);
      if (sensor_formula == FORMULA_OLD) begin
         if (fahr)
            t = ((m * OLD_F_GAIN) >> OLD_F_SHR) - OLD_F_OFS;
         else
            t = ((m * OLD_C_GAIN) >> OLD_C_SHR) - OLD_C_OFS;
      end else begin
         if (fahr)
            t = ((m * NEW_F_GAIN) >> NEW_F_SHR) - NEW_F_OFS;
         else
            // floor division by 32 on a possibly negative value
            t = (((m * NEW_C_GAIN) >> NEW_C_SHR) - NEW_C_OFS) >>> NEW_C_DIV;
      end
      if (t > HOT_LIMIT)
         t = HOT_LIMIT;
      if (t < COLD_LIMIT)
         t = COLD_LIMIT;
      return t;
   endfunction

   function automatic logic [7:0] digit(int d);
      return CHAR_ZERO + 8'(d);
   endfunction

   function automatic void owe(logic [7:0] ch, logic kind, logic last);
      rsp_type r;
      r.text_char   = ch;
      r.report_kind = kind;
      r.last_char   = last;
      report_words_q.push_back(r);
   endfunction

   function automatic void take_request(req_type w);
      logic fahr;
      logic known;
      int   t;
      int   mag;
      int   volts;
      case (w.mode)
         MODE_SAMPLE: begin
            temp_mean = smooth(temp_alpha, w.temp_sample, temp_mean);
            vcc_mean  = smooth(vcc_alpha, w.vcc_sample, vcc_mean);
            // counter and flags freeze once both are ready
            if (!vcc_ready || !temp_ready) begin
               if (sample_count != 8'hFF)
                  sample_count = sample_count + 8'd1;
               vcc_ready  = sample_count >= vcc_ready_count;
               temp_ready = sample_count >= temp_ready_count;
            end
         end
         MODE_BYTE: begin
            known = 1'b1;
            fahr  = 1'b0;
            if (w.rx_byte == CHAR_F_UP || w.rx_byte == CHAR_F_LO)
               fahr = 1'b1;
            else if (w.rx_byte != CHAR_C_UP && w.rx_byte != CHAR_C_LO)
               known = 1'b0;
            if (known && temp_ready) begin
               t   = temp_reading(fahr);
               mag = (t < 0) ? -t : t;
               if (t < 0)
                  owe(CHAR_MINUS, KIND_TEMP, 1'b0);
               if (mag > 99) begin
                  owe(digit(mag / 100), KIND_TEMP, 1'b0);
                  owe(digit((mag / 10) % 10), KIND_TEMP, 1'b0);
               end else if (mag > 9) begin
                  owe(digit(mag / 10), KIND_TEMP, 1'b0);
               end
               owe(digit(mag % 10), KIND_TEMP, 1'b0);
               owe(CHAR_DEG, KIND_TEMP, 1'b0);
               owe(fahr ? CHAR_F_UP : CHAR_C_UP, KIND_TEMP, 1'b0);
               owe(CHAR_LF, KIND_TEMP, 1'b0);
               owe(CHAR_CR, KIND_TEMP, 1'b1);
            end
         end
         MODE_TICK: begin
            if (vcc_ready) begin
               volts = int'(vcc_mean) / VOLT_STEP;
               if (volts > VOLT_CAP)
                  volts = VOLT_CAP;
               owe(digit(volts / 10), KIND_VOLT, 1'b0);
               owe(CHAR_DOT, KIND_VOLT, 1'b0);
               owe(digit(volts % 10), KIND_VOLT, 1'b0);
               owe(CHAR_V_UP, KIND_VOLT, 1'b0);
               owe(CHAR_LF, KIND_VOLT, 1'b0);
               owe(CHAR_CR, KIND_VOLT, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fault_total++;
         $error("%s mismatch: expected %h, actual %h", field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         temp_alpha       = 8'd64;
         vcc_alpha        = 8'd64;
         temp_ready_count = 8'd20;
         vcc_ready_count  = 8'd20;
         sensor_formula   = FORMULA_OLD;
         temp_mean        = '0;
         vcc_mean         = '0;
         sample_count     = '0;
         temp_ready       = 1'b0;
         vcc_ready        = 1'b0;
         report_words_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_words_q.size() == 0) begin
               fault_total++;
               $error("report word with none owed: text_char %h, report_kind %b, last_char %b",
                      rsp_data.text_char, rsp_data.report_kind, rsp_data.last_char);
            end else begin
               want = report_words_q.pop_front();
               compare_field("text_char", want.text_char, rsp_data.text_char);
               compare_field("report_kind", 8'(want.report_kind), 8'(rsp_data.report_kind));
               compare_field("last_char", 8'(want.last_char), 8'(rsp_data.last_char));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP_ALPHA:       temp_alpha = csr_wdata;
               CSR_VCC_ALPHA:        vcc_alpha = csr_wdata;
               CSR_TEMP_READY_COUNT: temp_ready_count = csr_wdata;
               CSR_VCC_READY_COUNT:  vcc_ready_count = csr_wdata;
               CSR_SENSOR_FORMULA:   sensor_formula = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_request(req_data);
      end
      words_owed <= report_words_q.size();
   end

endmodule

@@ dv/tb_sensor_average_report_formatter.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the sensor average report formatter: directed words,
// then phases of random words under several register settings; needs sarf_pkg
module tb_sensor_average_report_formatter;
   import sarf_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 37;
   // means at which the four temperature scalings pass through zero
   localparam int ZERO_CROSS[4] = '{1048, 1114, 1521, 1617};

   typedef struct packed {
      logic [CSR_IDX_W-1:0] idx;
      logic [7:0]           val;
   } reg_write_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   int                   fault_count;
   int                   words_owed;
   int                   cycle_count = 0;
   int                   idle_pct    = 35;
   int                   stall_pct   = 35;
   reg_write_type        reg_writes[$];

   sensor_average_report_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sarf_report_checker report_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count),
      .words_owed  (words_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type noise_word();
      req_type w;
      w.mode        = 2'($urandom);
      w.temp_sample = SAMPLE_BITS'($urandom);
      w.vcc_sample  = SAMPLE_BITS'($urandom);
      w.rx_byte     = 8'($urandom);
      return w;
   endfunction

   function automatic req_type sample_word(logic [SAMPLE_BITS-1:0] t,
                                           logic [SAMPLE_BITS-1:0] v);
      req_type w;
      w             = noise_word();
      w.mode        = MODE_SAMPLE;
      w.temp_sample = t;
      w.vcc_sample  = v;
      return w;
   endfunction

   function automatic req_type byte_word(logic [7:0] b);
      req_type w;
      w         = noise_word();
      w.mode    = MODE_BYTE;
      w.rx_byte = b;
      return w;
   endfunction

   function automatic req_type tick_word();
      req_type w;
      w      = noise_word();
      w.mode = MODE_TICK;
      return w;
   endfunction

   // extremes, values near a zero crossing, or anything
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return $urandom_range(1) ? '1 : '0;
      if (r < 45)
         return SAMPLE_BITS'(ZERO_CROSS[$urandom_range(3)] + $urandom_range(160) - 80);
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic void random_word(output req_type w, output bit counted);
      int             r;
      logic [7:0]     asks[4];
      asks    = '{CHAR_C_LO, CHAR_C_UP, CHAR_F_LO, CHAR_F_UP};
      r       = $urandom_range(99);
      counted = 1'b1;
      if (r < 45) begin
         w = sample_word(pick_sample(), pick_sample());
      end else if (r < 75) begin
         w = byte_word(asks[$urandom_range(3)]);
      end else if (r < 80) begin
         w = byte_word(8'($urandom));
         counted = (w.rx_byte == CHAR_C_LO || w.rx_byte == CHAR_C_UP ||
                    w.rx_byte == CHAR_F_LO || w.rx_byte == CHAR_F_UP);
      end else if (r < 95) begin
         w = tick_word();
      end else begin
         w       = noise_word();
         w.mode  = MODE_NONE;
         counted = 1'b0;
      end
   endfunction

   // valid stays high after a word is taken unless the next cycle idles
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_random_words(input int wanted);
      int      sent;
      req_type w;
      bit      counted;
      sent = 0;
      while (sent < wanted) begin
         random_word(w, counted);
         send_word(w);
         if (counted)
            sent++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (words_owed != 0);
      // a word that gives no report may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      reg_write_type rw;
      rw.idx = idx;
      rw.val = val;
      reg_writes.push_back(rw);
   endtask

   task automatic apply_regs();
      foreach (reg_writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= reg_writes[i].idx;
         csr_wdata <= reg_writes[i].val;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
      reg_writes.delete();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // nothing ready yet: requests and ticks stay silent
      send_word(byte_word(CHAR_C_LO));
      send_word(byte_word(CHAR_F_UP));
      send_word(tick_word());
      send_word('1);
      send_word(byte_word(8'hFF));
      send_word(byte_word(8'h00));
      send_word(sample_word('1, '1));
      send_word(sample_word('0, '0));
      send_word(sample_word('1, '0));
      send_word(sample_word('0, '1));
      send_word(byte_word(CHAR_C_UP));
      wait_drained();

      // voltage ready on the next word, temperature far off
      set_reg(CSR_VCC_READY_COUNT, 8'd1);
      set_reg(CSR_TEMP_READY_COUNT, 8'd255);
      set_reg(CSR_TEMP_ALPHA, 8'd255);
      set_reg(CSR_VCC_ALPHA, 8'd1);
      apply_regs();
      send_word(sample_word(12'd800, '1));
      send_word(tick_word());
      send_word(byte_word(CHAR_F_LO));
      send_random_words(PHASE_WORDS);
      wait_drained();

      // voltage flag drops again while temperature comes ready
      set_reg(CSR_VCC_READY_COUNT, 8'd255);
      set_reg(CSR_TEMP_READY_COUNT, 8'd1);
      set_reg(CSR_SENSOR_FORMULA, {7'd0, FORMULA_NEW});
      apply_regs();
      send_random_words(PHASE_WORDS);
      wait_drained();

      // both ready from here on, counter frozen
      set_reg(CSR_VCC_READY_COUNT, 8'd20);
      set_reg(CSR_TEMP_ALPHA, 8'd1);
      set_reg(CSR_VCC_ALPHA, 8'd255);
      apply_regs();
      send_random_words(PHASE_WORDS);
      wait_drained();

      // a phase with no idling on either side
      idle_pct  = 0;
      stall_pct = 0;
      set_reg(CSR_SENSOR_FORMULA, {7'd0, FORMULA_OLD});
      set_reg(CSR_TEMP_ALPHA, 8'd128);
      set_reg(CSR_VCC_ALPHA, 8'd64);
      apply_regs();
      send_random_words(PHASE_WORDS);
      wait_drained();
      idle_pct  = 35;
      stall_pct = 35;

      set_reg(CSR_TEMP_ALPHA, 8'($urandom_range(255, 1)));
      set_reg(CSR_VCC_ALPHA, 8'($urandom_range(255, 1)));
      set_reg(CSR_TEMP_READY_COUNT, 8'($urandom_range(255, 1)));
      set_reg(CSR_VCC_READY_COUNT, 8'($urandom_range(255, 1)));
      set_reg(CSR_SENSOR_FORMULA, {7'd0, 1'($urandom)});
      apply_regs();
      send_random_words(PHASE_WORDS);
      wait_drained();

      // full-scale means saturate Fahrenheit hot, then near zero saturates cold
      set_reg(CSR_TEMP_ALPHA, 8'd255);
      set_reg(CSR_VCC_ALPHA, 8'd255);
      set_reg(CSR_SENSOR_FORMULA, {7'd0, FORMULA_NEW});
      apply_regs();
      send_word(sample_word('1, '1));
      send_word(sample_word('1, '1));
      send_word(byte_word(CHAR_F_UP));
      send_word(byte_word(CHAR_F_LO));
      send_word(byte_word(CHAR_C_LO));
      send_word(byte_word(CHAR_C_UP));
      send_word(tick_word());
      send_word(sample_word('0, '0));
      send_word(sample_word('0, '0));
      send_word(byte_word(CHAR_C_LO));
      send_word(byte_word(CHAR_F_UP));
      send_random_words(PHASE_WORDS);
      wait_drained();

      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
